[rtl/isrt_pkg.sv]
// ----------------------------------------------------------------------------
// isrt_pkg
// Shared constants and types for the insertion sorter cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package isrt_pkg;

    localparam int CAPACITY = 32;   // number of cells, 2..64
    localparam int VALUE_W  = 32;

    // What one cell shows to its neighbors.
    typedef struct packed {
        logic               valid;
        logic               gt;      // holds a value strictly greater than the new one
        logic [VALUE_W-1:0] value;
    } isrt_link_t;

    // Chain-wide command for the current cycle.
    typedef struct packed {
        logic insert;   // place the broadcast value
        logic shift;    // move every entry one cell toward the head
    } isrt_ctrl_t;

endpackage

`default_nettype wire

[rtl/insertion_sorter.sv]
// ----------------------------------------------------------------------------
// insertion_sorter
// Stable ascending insertion sort over a set of values, built as a chain of
// compare-and-shift cells; the set is emitted in order on its end mark.
// ----------------------------------------------------------------------------
//  channel | signals                                   | role
//  --------+-------------------------------------------+----------------------
//  in      | in_valid, in_ready, value, end_of_set     | values to sort
//  out     | out_valid, out_ready, sorted_value,       | sorted set, one value
//          | last, overflow                            | per item
//
//  Insert: one item per cycle outside a drain; all cells compare against the
//  new value at once. An item with end_of_set starts a drain of the stored values
//  (at most CAPACITY); in_ready is low during the drain, and the chain shifts
//  toward the output register only when that register is free or being taken.
//  Reset empties the chain (valid bits only) and clears the overflow mark.
//  Values arriving with the chain full are dropped and flag the whole set.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sorter
    import isrt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic               end_of_set,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [VALUE_W-1:0]      sorted_value,
    output logic                    last,
    output logic                    overflow
);

    // link[0] is a virtual head, link[i+1] is cell i, link[CAPACITY+1] an empty tail
    isrt_link_t         link [CAPACITY+2];
    isrt_ctrl_t         ctrl;
    logic               accept;
    logic               full;
    logic               final_out;
    logic [CAPACITY-1:0] valid_vec;

    logic               drain_reg;
    logic               drain_next;
    logic               dropped_reg;
    logic               dropped_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;
    logic               out_ovf_reg;

    assign link[0].valid          = 1'b1;
    assign link[0].gt             = 1'b0;
    assign link[0].value          = '0;
    assign link[CAPACITY+1].valid = 1'b0;
    assign link[CAPACITY+1].gt    = 1'b0;
    assign link[CAPACITY+1].value = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        isrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .new_value (value),
            .left      (link[i]),
            .right     (link[i+2]),
            .link      (link[i+1])
        );
        assign valid_vec[i] = link[i+1].valid;
    end

    assign in_ready    = !drain_reg;
    assign accept      = in_valid && in_ready;
    assign full        = link[CAPACITY].valid;
    assign ctrl.insert = accept && !full;
    assign ctrl.shift  = drain_reg && (!out_valid_reg || out_ready);
    assign final_out   = !link[2].valid;   // cell 1 empty: head is the last value

    always_comb
    begin
        drain_next     = drain_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            if (end_of_set)
            begin
                drain_next = 1'b1;
            end
        end
        if (ctrl.shift)
        begin
            out_valid_next = 1'b1;
            if (final_out)
            begin
                drain_next   = 1'b0;
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            drain_reg     <= drain_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            out_value_reg <= link[1].value;
            out_last_reg  <= final_out;
            out_ovf_reg   <= dropped_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign last         = out_last_reg;
    assign overflow     = out_ovf_reg;

    // occupied cells always form an unbroken run from the head
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + CAPACITY'(1))) == '0)
        else $error("chain has a gap in its occupied cells");

    // a drain never runs on an empty head cell
    a_drain_head: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> link[1].valid)
        else $error("drain with empty head cell");

    // taking the final value ends the drain and leaves the chain empty
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.shift && final_out) |=> (!drain_reg && !link[1].valid))
        else $error("drain did not end after final value");

    // a drain is entered only from an accepted end-of-set item
    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(drain_reg) |-> $past(accept && end_of_set))
        else $error("drain started without end-of-set item");

endmodule

`default_nettype wire

[rtl/isrt_cell.sv]
// ----------------------------------------------------------------------------
// isrt_cell
// One slot of the sorted chain: compares, takes the new value or its left
// neighbor's on an insert, or from its right neighbor while the list drains.
// ----------------------------------------------------------------------------
`default_nettype none

module isrt_cell
    import isrt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire isrt_ctrl_t         ctrl,
    input  wire logic [VALUE_W-1:0] new_value,
    input  wire isrt_link_t         left,
    input  wire isrt_link_t         right,
    output isrt_link_t              link
);

    logic               valid_reg;
    logic               valid_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               gt;

    assign gt = valid_reg && (value_reg > new_value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.shift)
        begin
            valid_next = right.valid;
            value_next = right.value;
        end
        else if (ctrl.insert)
        begin
            if (left.gt)
            begin
                // larger entries move one slot toward the tail
                valid_next = 1'b1;
                value_next = left.value;
            end
            else if ((gt || !valid_reg) && left.valid)
            begin
                // insertion point: first slot past all entries <= new value
                valid_next = 1'b1;
                value_next = new_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign link.value = value_reg;

endmodule

`default_nettype wire
